[hdl/gcd_pkg.sv]
package gcd_pkg;

  localparam logic [31:0] HALF_TURN_UNITS    = 32'd3600000000;
  localparam logic [30:0] QUARTER_TURN_UNITS = 31'd1800000000;
  localparam logic [30:0] EARTH_DIAM_CM      = 31'd1274201760;
  localparam logic [30:0] HALF_CIRC_CM       = 31'd2001511444;

  function automatic logic [63:0] div_odd(input logic [63:0] p, input int unsigned k);
    logic [63:0] q;
    case (k)
      0: q = p;            1: q = p / 64'd3;    2: q = p / 64'd5;    3: q = p / 64'd7;
      4: q = p / 64'd9;    5: q = p / 64'd11;   6: q = p / 64'd13;   7: q = p / 64'd15;
      8: q = p / 64'd17;   9: q = p / 64'd19;   10: q = p / 64'd21;  11: q = p / 64'd23;
      12: q = p / 64'd25;  13: q = p / 64'd27;  14: q = p / 64'd29;  15: q = p / 64'd31;
      16: q = p / 64'd33;  17: q = p / 64'd35;  18: q = p / 64'd37;  19: q = p / 64'd39;
      20: q = p / 64'd41;  21: q = p / 64'd43;  22: q = p / 64'd45;  23: q = p / 64'd47;
      24: q = p / 64'd49;  25: q = p / 64'd51;  26: q = p / 64'd53;  27: q = p / 64'd55;
      28: q = p / 64'd57;  29: q = p / 64'd59;  30: q = p / 64'd61;
      default: q = '0;
    endcase
    return q;
  endfunction

  // arctangent of 1/5 or 1/239 in Q62 by its power series
  function automatic logic [63:0] atan_recip_q62(input bit use_239);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] sum;
    p = use_239 ? (64'd1 << 62) / 64'd239 : (64'd1 << 62) / 64'd5;
    sum = '0;
    for (int unsigned k = 0; k < 31; k++) begin
      if (p != '0) begin
        t = div_odd(p, k);
        sum = k[0] ? sum - t : sum + t;
        p = use_239 ? p / 64'd57121 : p / 64'd25;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi_q62();
    return 64'd4 * atan_recip_q62(1'b0) - atan_recip_q62(1'b1);
  endfunction

  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0] v;
    logic [63:0] t;
    v = '0;
    if (i == 0) begin
      v = quarter_pi_q62();
    end else begin
      for (int unsigned k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          t = div_odd(64'd1 << (62 - i * (2 * k + 1)), k);
          v = k[0] ? v - t : v + t;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] atan_entry(input int unsigned i, input int unsigned f);
    return (atan_q62(i) + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // radians per 5e-8 degree, scaled by 2^(f+32)
  function automatic logic [63:0] rad_per_unit(input int unsigned f);
    logic [63:0] pi;
    logic [63:0] q;
    logic [63:0] r;
    pi = 64'd4 * quarter_pi_q62();
    q = pi / 64'd3600000000;
    r = pi % 64'd3600000000;
    if (f >= 30) begin
      return (q << (f - 30)) + (((r << (f - 30)) + 64'd1800000000) / 64'd3600000000);
    end
    return ((pi + (64'd3600000000 << (29 - f))) / 64'd3600000000) >> (30 - f);
  endfunction

endpackage

[hdl/gcd_fold.sv]
module gcd_fold #(
  parameter int IW = 32,
  parameter bit SUBTRACT = 1'b1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] a,
  input  logic signed [IW-1:0] b,
  output logic        [30:0]   u
);
  import gcd_pkg::*;

  localparam int VW = IW + 1;
  localparam int MW = (VW > 32) ? VW : 32;

  logic signed [VW-1:0] sum;
  logic        [VW-1:0] mag;
  logic        [31:0]   red;
  logic        [MW-1:0] mag_ext;

  assign mag_ext = MW'(mag);

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUBTRACT ? VW'(a) - VW'(b) : VW'(a) + VW'(b);
      mag <= sum[VW-1] ? VW'(-sum) : VW'(sum);
      red <= (mag_ext >= MW'(HALF_TURN_UNITS)) ? 32'(mag_ext - MW'(HALF_TURN_UNITS))
                                               : 32'(mag_ext);
      u   <= (red > 32'(QUARTER_TURN_UNITS)) ? 31'(HALF_TURN_UNITS - red) : red[30:0];
    end
  end

endmodule

[hdl/gcd_mul.sv]
module gcd_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SHIFT = 30,
  parameter int OW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);

  localparam int LA = (AW > 32) ? 32 : AW;
  localparam int HA = (AW > 32) ? AW - 32 : 1;
  localparam int LB = (BW > 32) ? 32 : BW;
  localparam int HB = (BW > 32) ? BW - 32 : 1;
  localparam int SW = AW + BW + OW + 2;
  localparam logic [SW-1:0] HALF_LSB = SW'(1) << (SHIFT - 1);

  logic [LA+HA-1:0] a_pad;
  logic [LB+HB-1:0] b_pad;
  logic [LA-1:0]    a_lo;
  logic [HA-1:0]    a_hi;
  logic [LB-1:0]    b_lo;
  logic [HB-1:0]    b_hi;
  logic [LA+LB-1:0] pp_ll;
  logic [LA+HB-1:0] pp_lh;
  logic [HA+LB-1:0] pp_hl;
  logic [HA+HB-1:0] pp_hh;
  logic [SW-1:0]    acc;
  logic [SW-1:0]    rnd;

  assign a_pad = (LA + HA)'(a);
  assign b_pad = (LB + HB)'(b);
  assign a_lo  = a_pad[LA-1:0];
  assign a_hi  = a_pad[LA+HA-1:LA];
  assign b_lo  = b_pad[LB-1:0];
  assign b_hi  = b_pad[LB+HB-1:LB];
  assign rnd   = acc + HALF_LSB;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (LA + LB)'(a_lo) * (LA + LB)'(b_lo);
      pp_lh <= (LA + HB)'(a_lo) * (LA + HB)'(b_hi);
      pp_hl <= (HA + LB)'(a_hi) * (HA + LB)'(b_lo);
      pp_hh <= (HA + HB)'(a_hi) * (HA + HB)'(b_hi);
      acc   <= SW'(pp_ll) + (SW'(pp_lh) << LB) + (SW'(pp_hl) << LA)
             + (SW'(pp_hh) << (LA + LB));
      p     <= OW'(rnd >> SHIFT);
    end
  end

endmodule

[hdl/gcd_cell.sv]
module gcd_cell #(
  parameter int XW = 35,
  parameter int ZW = 33,
  parameter int SHIFT = 0,
  parameter bit VECTORING = 1'b0,
  parameter logic [63:0] ANGLE = 64'd0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] STEP = ANGLE[ZW-1:0];

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 ccw;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (VECTORING) begin
      ccw = y_in[XW-1] || (y_in == '0);
    end else begin
      ccw = !z_in[ZW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= ccw ? x_in - ys : x_in + ys;
      y_out <= ccw ? y_in + xs : y_in - xs;
      z_out <= ccw ? z_in - STEP : z_in + STEP;
    end
  end

endmodule

[hdl/great_circle_distance_core.sv]
// Haversine great-circle distance, fully pipelined.
// Throughput: one item per cycle when the output is not stalled.
// Three CORDIC cell rows in series set the depth.
// A stalled output holds the whole pipeline; pair_ready follows the output register.
// Reset (synchronous, active high) clears all valid flags; no payload is cleared.
module great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = 30,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_ready,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               dist_valid,
  input  logic               dist_ready,
  output logic        [30:0] distance_cm
);
  import gcd_pkg::*;

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int XW  = F + 5;
  localparam int ZW  = F + 3;
  localparam int CW  = F + 1;
  localparam int PW  = F + 2;
  localparam int HW  = F + 3;
  localparam int RW  = F + 2;
  localparam int LAT = 3 * N + 14;
  localparam logic [RW-1:0] RAD_PER_UNIT = RW'(rad_per_unit(F));
  localparam logic signed [XW-1:0] X_ONE = XW'(64'd1 << F);

  logic                 adv;
  logic [LAT-1:0]       vld;
  logic signed [31:0]   fold_a [3];
  logic signed [31:0]   fold_b [3];
  logic [30:0]          fold_u [3];
  logic [ZW-1:0]        z_start [3];
  logic signed [XW-1:0] rot_x [3][N+1];
  logic signed [XW-1:0] rot_y [3][N+1];
  logic signed [ZW-1:0] rot_z [3][N+1];
  logic [CW-1:0]        cos_q [3];
  logic [CW-1:0]        sin_q [3];
  logic [CW-1:0]        prod_a [4];
  logic [CW-1:0]        prod_b [4];
  logic [PW-1:0]        prod [4];
  logic signed [XW-1:0] vec_x [3][N+1];
  logic signed [XW-1:0] vec_y [3][N+1];
  logic signed [ZW-1:0] vec_z [3][N+1];
  logic [HW-1:0]        hx;
  logic [HW-1:0]        hy;
  logic [CW-1:0]        ang;
  logic [31:0]          dist_raw;

  assign adv        = !vld[LAT-1] || dist_ready;
  assign pair_ready = adv;
  assign dist_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], pair_valid};
    end
  end

  assign fold_a[0] = 32'(lat_a);
  assign fold_b[0] = 32'(lat_b);
  assign fold_a[1] = 32'(lat_a);
  assign fold_b[1] = 32'(lat_b);
  assign fold_a[2] = lon_a;
  assign fold_b[2] = lon_b;

  for (genvar j = 0; j < 3; j++) begin : g_rot
    gcd_fold #(.IW(32), .SUBTRACT(j != 1)) u_fold (
      .clk(clk), .en(adv), .a(fold_a[j]), .b(fold_b[j]), .u(fold_u[j])
    );

    gcd_mul #(.AW(31), .BW(RW), .SHIFT(32), .OW(ZW)) u_zmul (
      .clk(clk), .en(adv), .a(fold_u[j]), .b(RAD_PER_UNIT), .p(z_start[j])
    );

    assign rot_x[j][0] = X_ONE;
    assign rot_y[j][0] = '0;
    assign rot_z[j][0] = z_start[j];

    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cell #(
        .XW(XW), .ZW(ZW), .SHIFT(i), .VECTORING(1'b0), .ANGLE(atan_entry(i, F))
      ) u_cell (
        .clk(clk), .en(adv),
        .x_in(rot_x[j][i]), .y_in(rot_y[j][i]), .z_in(rot_z[j][i]),
        .x_out(rot_x[j][i+1]), .y_out(rot_y[j][i+1]), .z_out(rot_z[j][i+1])
      );
    end

    assign cos_q[j] = rot_x[j][N][XW-1] ? '0 : rot_x[j][N][CW-1:0];
    assign sin_q[j] = rot_y[j][N][XW-1] ? '0 : rot_y[j][N][CW-1:0];
  end

  assign prod_a[0] = sin_q[0];
  assign prod_b[0] = cos_q[2];
  assign prod_a[1] = cos_q[1];
  assign prod_b[1] = sin_q[2];
  assign prod_a[2] = cos_q[0];
  assign prod_b[2] = cos_q[2];
  assign prod_a[3] = sin_q[1];
  assign prod_b[3] = sin_q[2];

  for (genvar k = 0; k < 4; k++) begin : g_prod
    gcd_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(PW)) u_pmul (
      .clk(clk), .en(adv), .a(prod_a[k]), .b(prod_b[k]), .p(prod[k])
    );
  end

  assign hy = vec_x[0][N][XW-1] ? '0 : vec_x[0][N][HW-1:0];
  assign hx = vec_x[1][N][XW-1] ? '0 : vec_x[1][N][HW-1:0];

  assign vec_x[0][0] = XW'(prod[0]);
  assign vec_y[0][0] = XW'(prod[1]);
  assign vec_x[1][0] = XW'(prod[2]);
  assign vec_y[1][0] = XW'(prod[3]);
  assign vec_x[2][0] = XW'(hx);
  assign vec_y[2][0] = XW'(hy);

  for (genvar j = 0; j < 3; j++) begin : g_vec
    assign vec_z[j][0] = '0;
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cell #(
        .XW(XW), .ZW(ZW), .SHIFT(i), .VECTORING(1'b1), .ANGLE(atan_entry(i, F))
      ) u_cell (
        .clk(clk), .en(adv),
        .x_in(vec_x[j][i]), .y_in(vec_y[j][i]), .z_in(vec_z[j][i]),
        .x_out(vec_x[j][i+1]), .y_out(vec_y[j][i+1]), .z_out(vec_z[j][i+1])
      );
    end
  end

  assign ang = vec_z[2][N][ZW-1] ? '0 : vec_z[2][N][CW-1:0];

  gcd_mul #(.AW(CW), .BW(31), .SHIFT(F), .OW(32)) u_dmul (
    .clk(clk), .en(adv), .a(ang), .b(EARTH_DIAM_CM), .p(dist_raw)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      distance_cm <= (dist_raw > 32'(HALF_CIRC_CM)) ? HALF_CIRC_CM : dist_raw[30:0];
    end
  end

endmodule

[hdl/gcd_check.sv]
module gcd_check (
  input logic        clk,
  input logic        rst,
  input logic        pair_ready,
  input logic        dist_valid,
  input logic        dist_ready,
  input logic [30:0] distance_cm
);
  import gcd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dist_valid && !dist_ready |=> dist_valid && $stable(distance_cm))
    else $error("result dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> distance_cm <= HALF_CIRC_CM)
    else $error("distance beyond half circumference");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !dist_valid |-> pair_ready)
    else $error("input blocked with empty output");

  a_reset: assert property (@(posedge clk)
    rst |=> !dist_valid)
    else $error("result valid after reset");

endmodule

bind great_circle_distance_core gcd_check u_gcd_check (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import gcd_pkg::*;

  localparam int AFB = 30;
  localparam int NST = 32;
  localparam int LATENCY = 3 * NST + 14;
  localparam int N_RANDOM = 1650;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
  } point_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_ready;
  logic signed [30:0] lat_a = '0;
  logic signed [31:0] lon_a = '0;
  logic signed [30:0] lat_b = '0;
  logic signed [31:0] lon_b = '0;
  logic dist_valid;
  logic dist_ready = 1'b0;
  logic [30:0] distance_cm;

  longint cycles = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  great_circle_distance_core #(.ANGLE_FRAC_BITS(AFB), .CORDIC_STAGES(NST)) uut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .dist_valid(dist_valid), .dist_ready(dist_ready), .distance_cm(distance_cm)
  );

  class distance_scoreboard;
    logic [30:0] pending[$];
    int mismatches = 0;
    int checked = 0;
    longint unsigned atan_q[NST];
    longint unsigned rad_unit;

    function longint unsigned series_q62(longint unsigned n);
      longint unsigned p, s, k, t;
      p = (64'd1 << 62) / n;
      s = 0;
      k = 0;
      while (p != 0) begin
        t = p / (2 * k + 1);
        s = k[0] ? s - t : s + t;
        p = p / (n * n);
        k++;
      end
      return s;
    endfunction

    function new();
      longint unsigned qpi, v, t, pi_q;
      qpi = 4 * series_q62(5) - series_q62(239);
      for (int i = 0; i < NST; i++) begin
        v = 0;
        if (i == 0) v = qpi;
        else begin
          for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            t = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            v = k[0] ? v - t : v + t;
          end
        end
        atan_q[i] = (v + (64'd1 << (61 - AFB))) >> (62 - AFB);
      end
      pi_q = qpi * 4;
      rad_unit = ((pi_q / 64'd3600000000) << (AFB - 30)) +
                 (((pi_q % 64'd3600000000) << (AFB - 30)) + 64'd1800000000) / 64'd3600000000;
    endfunction

    function longint unsigned rmul(longint unsigned a, longint unsigned b, int s);
      logic [127:0] p;
      p = a * 128'(b) + (128'd1 << (s - 1));
      return 64'(p >> s);
    endfunction

    function longint unsigned fold_units(longint signed v);
      longint unsigned a;
      a = v < 0 ? -v : v;
      a = a % 64'd3600000000;
      if (a > 64'd1800000000) a = 64'd3600000000 - a;
      return a;
    endfunction

    function void rotate(longint unsigned u, output longint unsigned c,
                         output longint unsigned s);
      longint signed z, x, y, xs, ys;
      z = rmul(u, rad_unit, 32);
      x = 64'sd1 << AFB;
      y = 0;
      for (int i = 0; i < NST; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_q[i];
        end else begin
          x += ys; y -= xs; z += atan_q[i];
        end
      end
      c = x > 0 ? x : 0;
      s = y > 0 ? y : 0;
    endfunction

    function longint unsigned magnitude(longint unsigned x0, longint unsigned y0,
                                        output longint signed ang);
      longint signed x, y, z, xs, ys;
      x = x0; y = y0; z = 0;
      for (int i = 0; i < NST; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_q[i];
        end else begin
          x -= ys; y += xs; z -= atan_q[i];
        end
      end
      ang = z;
      return x > 0 ? x : 0;
    endfunction

    function logic [30:0] distance_of(point_pair_t p);
      longint unsigned cd, sd, cm, sm, cl, sl, hy, hx, d;
      longint signed la, lb, oa, ob, ang;
      la = p.lat_a; lb = p.lat_b; oa = p.lon_a; ob = p.lon_b;
      rotate(fold_units(la - lb), cd, sd);
      rotate(fold_units(la + lb), cm, sm);
      rotate(fold_units(oa - ob), cl, sl);
      hy = magnitude(rmul(sd, cl, AFB), rmul(cm, sl, AFB), ang);
      hx = magnitude(rmul(cd, cl, AFB), rmul(sm, sl, AFB), ang);
      void'(magnitude(hx, hy, ang));
      if (ang < 0) ang = 0;
      d = rmul(ang, 64'(EARTH_DIAM_CM), AFB);
      if (d > 64'(HALF_CIRC_CM)) d = HALF_CIRC_CM;
      return d[30:0];
    endfunction

    function void note_pair(point_pair_t p);
      pending.push_back(distance_of(p));
    endfunction

    function void check_distance(logic [30:0] got);
      logic [30:0] want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance_cm %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance_cm mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  distance_scoreboard sb = new();

  function automatic int rand_lat();
    case ($urandom_range(9))
      0: return $urandom_range(1, 0) ? 900000000 : -900000000;
      1: return int'($urandom) >>> 1;
      default: return int'($urandom_range(1800000000)) - 900000000;
    endcase
  endfunction

  function automatic int rand_lon();
    case ($urandom_range(9))
      0: return $urandom_range(1, 0) ? 1800000000 : -1800000000;
      1: return int'($urandom);
      default: return int'($urandom_range(3600000000)) - 1800000000;
    endcase
  endfunction

  task automatic send_pair(int la, int oa, int lb, int ob);
    while (!calm && $urandom_range(99) < 32) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair_valid <= 1'b1;
    lat_a <= la[30:0];
    lon_a <= oa;
    lat_b <= lb[30:0];
    lon_b <= ob;
    do @(posedge clk); while (!pair_ready);
    sb.note_pair('{la[30:0], oa, lb[30:0], ob});
  endtask

  task automatic send_near(int la, int oa);
    send_pair(la, oa, la + int'($urandom_range(200)) - 100,
              oa + int'($urandom_range(200)) - 100);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) dist_ready <= 1'b0;
    else dist_ready <= calm || ($urandom_range(99) >= 32);
    if (!rst && dist_valid && dist_ready) sb.check_distance(distance_cm);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int la;
    int oa;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pair(0, 0, 0, 0);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(0, 1800000000, 0, -1800000000);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, -1800000000, 0, 0);
    send_pair(-900000000, -1800000000, 900000000, 1800000000);
    send_pair(1073741823, 2147483647, -1073741824, -2147483648);
    send_pair(-1073741824, -2147483648, -1073741824, 2147483647);
    send_pair(1073741823, 0, 1073741823, 0);
    send_pair(0, 900000000, 0, -900000000);
    send_pair(450000000, 100, 450000000, 100);
    send_pair(1, 0, 0, 0);
    send_pair(0, 1, 0, 0);
    send_pair(899999999, 0, -900000000, 1800000000);
    send_pair(1, 0, -1, 1800000000);
    send_pair(515000000, -1000000, 407000000, -740000000);
    send_pair(-338000000, 1512000000, 515000000, -1000000);
    send_pair(-1073741824, 0, 0, 0);
    send_pair(0, -2147483648, 0, 0);
    send_pair(0, 0, 0, 2147483647);
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 900);
      la = rand_lat();
      oa = rand_lon();
      case ($urandom_range(9))
        0: send_near(la, oa);
        1: send_pair(la, oa, -la + int'($urandom_range(20)) - 10,
                     oa + 1800000000 + int'($urandom_range(20)) - 10);
        default: send_pair(la, oa, rand_lat(), rand_lon());
      endcase
    end
    calm = 1'b0;
    pair_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d distances over directed extremes, antipodes, coincident",
             sb.checked);
    $display("and random point pairs with stalls on both sides; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[files.f]
hdl/gcd_pkg.sv
hdl/gcd_fold.sv
hdl/gcd_mul.sv
hdl/gcd_cell.sv
hdl/great_circle_distance_core.sv
hdl/gcd_check.sv
test/tb_top.sv
